>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the buffer allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define BFBA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BFBA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/bfba_pkg.sv
// Package with the types and codes of the best-fit buffer allocator.
package bfba_pkg;

   // Command codes.
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   // Status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_SPACE  = 3'd1;
   localparam logic [2:0] STATUS_DUP_ID    = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP_SWEEP,
      ST_GAP_DONE,
      ST_CAND_RD,
      ST_CAND_CHK,
      ST_ID_SWEEP,
      ST_FINISH
   } state_type;

   // One entry of the slot table.
   typedef struct packed {
      logic [31:0] id;
      logic [31:0] offset;
      logic [31:0] size;
   } slot_entry_type;

   // Write controls toward the slot table.
   typedef struct packed {
      logic           wr_en;
      logic           clr_en;
      slot_entry_type entry;
   } slot_wr_type;

endpackage

>>> rtl/bfba_slot_store.sv
// Slot table: entry memory with a registered read port plus per-slot valid bits.
module bfba_slot_store #(
   parameter int SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output bfba_pkg::slot_entry_type      rd_data,
   output logic                          rd_valid,
   input  bfba_pkg::slot_wr_type         wr,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr
);
   import bfba_pkg::*;

   slot_entry_type mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   slot_entry_type   rd_data_ff;
   logic             rd_valid_ff;

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr_addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Valid bits are cleared by reset and read alongside the entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (wr.clr_en) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

>>> rtl/best_fit_buffer_allocator.sv
// Top level of the best-fit buffer allocator.
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Commands: allocate (best-fit gap, ties to the lowest offset), free by id, and
// a check whether any gap would hold request_size. Each command gives exactly
// one result beat, shown for one cycle with rsp_valid high; the receiver
// cannot stall it. The pool size is written through the csr_ channel while
// the block is idle.
// Free sweeps the slot table once by id. Allocate and check try the start at 0
// and the end of every stored buffer as a gap start, and size each one with a
// full sweep of the slot table; allocate then adds an id sweep when a gap fits.
// The slot memory has a single read port, which reads one entry per cycle
// during a sweep. One command is in work at a time; busy stays high until the
// result beat is issued.
// Reset empties the slot table (valid bits cleared at once) and sets the pool
// size to zero.
`include "assert_macros.svh"
module best_fit_buffer_allocator #(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_buffer_id,
   input  logic [31:0] req_request_size,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_start_offset,
   output logic [31:0] rsp_end_offset,
   output logic        rsp_pool_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);
   import bfba_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   state_type      state_ff, state_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [31:0]    id_ff, id_in;
   logic [31:0]    req_ff, req_in;
   logic [31:0]    mem_size_ff;
   logic [32:0]    s_ff, s_in;
   logic           first_ff, first_in;
   logic [IW-1:0]  c_ff, c_in;
   logic [IW-1:0]  a_ff, a_in;
   logic [IW-1:0]  b_ff, b_in;
   logic           last_ff, last_in;
   logic           pend_ff, pend_in;
   logic           cov_ff, cov_in;
   logic           bnd_ff, bnd_in;
   logic [31:0]    gend_ff, gend_in;
   logic           found_ff, found_in;
   logic [31:0]    boff_ff, boff_in;
   logic [31:0]    blen_ff, blen_in;
   logic           hit_ff, hit_in;
   logic [IW-1:0]  hit_idx_ff, hit_idx_in;
   logic           free_ok_ff, free_ok_in;
   logic [IW-1:0]  free_idx_ff, free_idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_start_ff, rsp_start_in;
   logic [31:0]    rsp_end_ff, rsp_end_in;
   logic           rsp_full_ff, rsp_full_in;

   logic           rd_en;
   logic [IW-1:0]  rd_addr;
   slot_entry_type rd_data;
   logic           rd_valid;
   slot_wr_type    wr;
   logic [IW-1:0]  wr_addr;

   logic [32:0]    entry_end;
   logic           entry_live;
   logic [31:0]    gap_end;
   logic [31:0]    gap_len;
   logic           adv;

   bfba_slot_store #(.SLOTS(SLOTS)) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rd_valid (rd_valid),
      .wr       (wr),
      .wr_addr  (wr_addr)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   // End of the entry returned by the memory and whether it covers any space.
   assign entry_end  = {1'b0, rd_data.offset} + {1'b0, rd_data.size};
   assign entry_live = rd_valid && (rd_data.size != 32'd0);

   // Length of the gap that starts at the current candidate.
   assign gap_end = bnd_ff ? gend_ff : mem_size_ff;
   assign gap_len = (!cov_ff && ({1'b0, gap_end} > s_ff)) ?
                    (gap_end - s_ff[31:0]) : 32'd0;

   // Next state and datapath.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      req_in        = req_ff;
      s_in          = s_ff;
      first_in      = first_ff;
      c_in          = c_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      last_in       = last_ff;
      pend_in       = pend_ff;
      cov_in        = cov_ff;
      bnd_in        = bnd_ff;
      gend_in       = gend_ff;
      found_in      = found_ff;
      boff_in       = boff_ff;
      blen_in       = blen_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_full_in   = rsp_full_ff;
      rd_en         = 1'b0;
      rd_addr       = a_ff;
      wr            = '0;
      wr_addr       = free_idx_ff;
      adv           = 1'b0;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               id_in    = req_buffer_id;
               req_in   = req_request_size;
               a_in     = '0;
               last_in  = 1'b0;
               pend_in  = 1'b0;
               if (req_command == CMD_ALLOC || req_command == CMD_CHECK) begin
                  s_in     = '0;
                  first_in = 1'b1;
                  found_in = 1'b0;
                  cov_in   = 1'b0;
                  bnd_in   = 1'b0;
                  state_in = ST_GAP_SWEEP;
               end else if (req_command == CMD_FREE) begin
                  hit_in     = 1'b0;
                  free_ok_in = 1'b0;
                  state_in   = ST_ID_SWEEP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_GAP_SWEEP, ST_ID_SWEEP: begin
            // Issue one read per cycle; handle the beat read in the cycle before.
            rd_en   = !last_ff;
            rd_addr = a_ff;
            pend_in = !last_ff;
            b_in    = a_ff;
            if (!last_ff) begin
               if (a_ff == LAST_IDX) begin
                  last_in = 1'b1;
               end else begin
                  a_in = a_ff + 1'b1;
               end
            end
            if (pend_ff) begin
               if (state_ff == ST_GAP_SWEEP) begin
                  if (entry_live && ({1'b0, rd_data.offset} <= s_ff) && (s_ff < entry_end)) begin
                     cov_in = 1'b1;
                  end
                  if (entry_live && ({1'b0, rd_data.offset} > s_ff) &&
                      (!bnd_ff || rd_data.offset < gend_ff)) begin
                     gend_in = rd_data.offset;
                     bnd_in  = 1'b1;
                  end
               end else begin
                  if (rd_valid && rd_data.id == id_ff && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = b_ff;
                  end
                  if (!rd_valid && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = b_ff;
                  end
               end
            end
            if (last_ff && !pend_ff) begin
               state_in = (state_ff == ST_GAP_SWEEP) ? ST_GAP_DONE : ST_FINISH;
            end
         end

         ST_GAP_DONE: begin
            // Keep the smallest fitting gap, lowest offset on a tie.
            if (gap_len != 32'd0 && gap_len >= req_ff &&
                (!found_ff || gap_len < blen_ff ||
                 (gap_len == blen_ff && s_ff[31:0] < boff_ff))) begin
               found_in = 1'b1;
               boff_in  = s_ff[31:0];
               blen_in  = gap_len;
            end
            adv = 1'b1;
         end

         ST_CAND_RD: begin
            rd_en    = 1'b1;
            rd_addr  = c_ff;
            state_in = ST_CAND_CHK;
         end

         ST_CAND_CHK: begin
            // A live buffer offers its end as the next gap start.
            if (entry_live) begin
               s_in     = entry_end;
               a_in     = '0;
               last_in  = 1'b0;
               pend_in  = 1'b0;
               cov_in   = 1'b0;
               bnd_in   = 1'b0;
               state_in = ST_GAP_SWEEP;
            end else begin
               adv = 1'b1;
            end
         end

         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_start_in  = '0;
            rsp_end_in    = '0;
            rsp_full_in   = 1'b0;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (!found_ff) begin
                     rsp_status_in = STATUS_NO_SPACE;
                  end else if (hit_ff) begin
                     rsp_status_in = STATUS_DUP_ID;
                  end else if (!free_ok_ff) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     wr.wr_en        = 1'b1;
                     wr.entry.id     = id_ff;
                     wr.entry.offset = boff_ff;
                     wr.entry.size   = req_ff;
                     wr_addr         = free_idx_ff;
                     rsp_start_in    = boff_ff;
                     rsp_end_in      = boff_ff + req_ff;
                  end
               end
               CMD_FREE: begin
                  if (hit_ff) begin
                     wr.clr_en = 1'b1;
                     wr_addr   = hit_idx_ff;
                  end else begin
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
               end
               CMD_CHECK: begin
                  rsp_full_in = !found_ff;
               end
               default: begin
               end
            endcase
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Step to the next candidate gap start, or leave the gap search.
      if (adv) begin
         first_in = 1'b0;
         if (first_ff) begin
            c_in     = '0;
            state_in = ST_CAND_RD;
         end else if (c_ff != LAST_IDX) begin
            c_in     = c_ff + 1'b1;
            state_in = ST_CAND_RD;
         end else if (cmd_ff == CMD_ALLOC && found_in) begin
            a_in       = '0;
            last_in    = 1'b0;
            pend_in    = 1'b0;
            hit_in     = 1'b0;
            free_ok_in = 1'b0;
            state_in   = ST_ID_SWEEP;
         end else begin
            state_in = ST_FINISH;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mem_size_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mem_size_ff <= csr_wdata;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      req_ff        <= req_in;
      s_ff          <= s_in;
      first_ff      <= first_in;
      c_ff          <= c_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      last_ff       <= last_in;
      pend_ff       <= pend_in;
      cov_ff        <= cov_in;
      bnd_ff        <= bnd_in;
      gend_ff       <= gend_in;
      found_ff      <= found_in;
      boff_ff       <= boff_in;
      blen_ff       <= blen_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_start_offset = rsp_start_ff;
   assign rsp_end_offset   = rsp_end_ff;
   assign rsp_pool_full    = rsp_full_ff;

   // A result beat leaves only after the work is done.
   `BFBA_ASSERT(a_rsp_idle, rsp_valid |-> !busy, "result beat while still busy")
   // An accepted command always keeps the block busy in the next cycle.
   `BFBA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not start")
   // A failed fit check carries an ok status.
   `BFBA_ASSERT(a_full_ok, rsp_valid && rsp_pool_full |-> rsp_status == STATUS_OK, "bad check")
   // No result beat comes out of reset.
   `BFBA_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result beat after reset")

endmodule

>>> dv/best_fit_buffer_allocator_test.sv
// Self-checking testbench for the best-fit buffer allocator: directed rows, then random phases.
module best_fit_buffer_allocator_test;
   import bfba_pkg::*;

   localparam int         SLOTS      = 64;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         IDLE_LIMIT = 50000;
   localparam int         PHASE_LEN  = 125;

   typedef enum logic {ROW_BEAT, ROW_POOL} row_kind_type;

   // One result beat as the block should give it.
   typedef struct {
      logic [2:0]  status;
      logic [31:0] start_offset;
      logic [31:0] end_offset;
      logic        pool_full;
   } alloc_result_type;

   // One row of the directed table; a pool row writes the pool size.
   typedef struct {
      row_kind_type     kind;
      logic [1:0]       command;
      logic [31:0]      buffer_id;
      logic [31:0]      request_size;
      bit               typed;
      alloc_result_type result;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [31:0] req_buffer_id;
   logic [31:0] req_request_size;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_start_offset;
   logic [31:0] rsp_end_offset;
   logic        rsp_pool_full;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_wdata;

   // Shadow copy of the pool size and the slot table.
   logic [63:0] pool_size;
   bit          shadow_valid [SLOTS];
   logic [31:0] shadow_id    [SLOTS];
   logic [63:0] shadow_off   [SLOTS];
   logic [63:0] shadow_size  [SLOTS];

   alloc_result_type pending_results[$];
   stim_row_type     table_rows[$];
   int               fail_count;
   int               idle_cycles;
   logic [31:0]      next_unique_id;

   best_fit_buffer_allocator #(.SLOTS(SLOTS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_buffer_id    (req_buffer_id),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_start_offset (rsp_start_offset),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_pool_full    (rsp_pool_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // Length of the free gap that starts at s, zero when none starts there.
   function automatic logic [63:0] gap_length(logic [63:0] s);
      logic [63:0] lim;
      logic [63:0] e;
      bit          bounded;
      lim     = 64'd0;
      bounded = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_valid[i] && shadow_size[i] != 64'd0) begin
            e = shadow_off[i] + shadow_size[i];
            if (shadow_off[i] <= s && s < e) return 64'd0;
            if (shadow_off[i] > s && (!bounded || shadow_off[i] < lim)) begin
               lim     = shadow_off[i];
               bounded = 1'b1;
            end
         end
      end
      if (!bounded) lim = pool_size;
      return (lim > s) ? lim - s : 64'd0;
   endfunction

   // Smallest gap holding req, ties to the lowest offset.
   function automatic bit best_gap(logic [63:0] req, output logic [63:0] best_off);
      bit          found;
      logic [63:0] best_len;
      logic [63:0] len;
      logic [63:0] s;
      found    = 1'b0;
      best_off = 64'd0;
      best_len = 64'd0;
      for (int i = -1; i < SLOTS; i++) begin
         if (i < 0 || (shadow_valid[i] && shadow_size[i] != 64'd0)) begin
            s   = (i < 0) ? 64'd0 : shadow_off[i] + shadow_size[i];
            len = gap_length(s);
            if (len != 64'd0 && len >= req &&
                (!found || len < best_len || (len == best_len && s < best_off))) begin
               found    = 1'b1;
               best_off = s;
               best_len = len;
            end
         end
      end
      return found;
   endfunction

   function automatic int slot_of_id(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_id[i] == id) return i;
      return -1;
   endfunction

   // Works out the result of one command and updates the shadow table.
   function automatic alloc_result_type allocate_predict(logic [1:0] cmd, logic [31:0] id,
                                                         logic [31:0] req);
      alloc_result_type r;
      logic [63:0]      off;
      int               slot;
      r    = '{STATUS_OK, 32'd0, 32'd0, 1'b0};
      slot = -1;
      case (cmd)
         CMD_ALLOC: begin
            if (!best_gap({32'd0, req}, off)) begin
               r.status = STATUS_NO_SPACE;
            end else if (slot_of_id(id) >= 0) begin
               r.status = STATUS_DUP_ID;
            end else begin
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!shadow_valid[i]) slot = i;
               if (slot < 0) begin
                  r.status = STATUS_FULL;
               end else begin
                  shadow_valid[slot] = 1'b1;
                  shadow_id[slot]    = id;
                  shadow_off[slot]   = off;
                  shadow_size[slot]  = {32'd0, req};
                  r.start_offset     = off[31:0];
                  r.end_offset       = off[31:0] + req;
               end
            end
         end
         CMD_FREE: begin
            slot = slot_of_id(id);
            if (slot < 0) r.status = STATUS_NOT_FOUND;
            else shadow_valid[slot] = 1'b0;
         end
         CMD_CHECK: begin
            r.pool_full = !best_gap({32'd0, req}, off);
         end
         default: ;
      endcase
      return r;
   endfunction

   // Id of a random stored buffer, or a random small id when none is stored.
   function automatic logic [31:0] live_id();
      int picks[$];
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i]) picks = {picks, i};
      if (picks.size() == 0) return $urandom_range(0, 15);
      return shadow_id[picks[$urandom_range(0, picks.size() - 1)]];
   endfunction

   // Sends one command beat; start stays high so the next beat can follow at once.
   task automatic send_beat(logic [1:0] cmd, logic [31:0] id, logic [31:0] req,
                            bit typed, alloc_result_type typed_result);
      alloc_result_type predicted;
      alloc_result_type expected;
      start            <= 1'b1;
      req_command      <= cmd;
      req_buffer_id    <= id;
      req_request_size <= req;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predicted       = allocate_predict(cmd, id, req);
      expected        = typed ? typed_result : predicted;
      pending_results = {pending_results, expected};
   endtask

   // Waits for the block to drain, then writes a new pool size.
   task automatic write_pool_size(logic [31:0] value);
      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      pool_size = {32'd0, value};
   endtask

   task automatic add_beat(logic [1:0] cmd, logic [31:0] id, logic [31:0] req, bit typed,
                           logic [2:0] st, logic [31:0] so, logic [31:0] eo, logic full);
      stim_row_type row;
      row        = '{ROW_BEAT, cmd, id, req, typed, '{st, so, eo, full}};
      table_rows = {table_rows, row};
   endtask

   task automatic add_pool(logic [31:0] value);
      stim_row_type row;
      row        = '{ROW_POOL, 2'd0, 32'd0, value, 1'b0, '{3'd0, 32'd0, 32'd0, 1'b0}};
      table_rows = {table_rows, row};
   endtask

   // Random command shaped by the current pool size.
   task automatic random_beat(bit fill);
      logic [1:0]  cmd;
      logic [31:0] id;
      logic [31:0] req;
      int          pick;
      pick = $urandom_range(0, 99);
      if (fill) cmd = (pick < 85) ? CMD_ALLOC : (pick < 95) ? CMD_FREE : CMD_CHECK;
      else cmd = (pick < 50) ? CMD_ALLOC : (pick < 78) ? CMD_FREE :
                 (pick < 95) ? CMD_CHECK : CMD_UNUSED;
      case ($urandom_range(0, 9))
         0:       id = $urandom;
         1, 2:    id = $urandom_range(0, 99);
         default: id = (cmd == CMD_FREE) ? live_id() : $urandom_range(0, 15);
      endcase
      if (fill && cmd == CMD_ALLOC) begin
         id             = next_unique_id;
         next_unique_id = next_unique_id + 32'd1;
      end
      case ($urandom_range(0, 9))
         0:       req = 32'd0;
         1:       req = $urandom;
         2:       req = pool_size[31:0];
         default: req = $urandom_range(1, pool_size[31:0] / 16 + 1);
      endcase
      send_beat(cmd, id, req, 1'b0, '{3'd0, 32'd0, 32'd0, 1'b0});
   endtask

   // Results are taken as they appear and held against the oldest expectation.
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, status %0d", $time, rsp_status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_start_offset !== want.start_offset) begin
               $display("%0t: start_offset expected %0h actual %0h", $time,
                        want.start_offset, rsp_start_offset);
               fail_count++;
            end
            if (rsp_end_offset !== want.end_offset) begin
               $display("%0t: end_offset expected %0h actual %0h", $time,
                        want.end_offset, rsp_end_offset);
               fail_count++;
            end
            if (rsp_pool_full !== want.pool_full) begin
               $display("%0t: pool_full expected %0b actual %0b", $time,
                        want.pool_full, rsp_pool_full);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] pool_choice [10];
      int          burst;
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_command      = CMD_ALLOC;
      req_buffer_id    = 32'd0;
      req_request_size = 32'd0;
      csr_valid        = 1'b0;
      csr_wdata        = 32'd0;
      next_unique_id   = 32'h1000_0000;
      pool_size        = 64'd0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_id[i]    = 32'd0;
         shadow_off[i]   = 64'd0;
         shadow_size[i]  = 64'd0;
      end

      // Directed rows; pool size is zero out of reset.
      add_beat(CMD_ALLOC, 32'd5, 32'd1, 1'b1, STATUS_NO_SPACE, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_ALLOC, 32'd5, 32'd0, 1'b1, STATUS_NO_SPACE, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_CHECK, 32'd0, 32'd0, 1'b1, STATUS_OK, 32'd0, 32'd0, 1'b1);
      add_beat(CMD_FREE, 32'd7, 32'd0, 1'b1, STATUS_NOT_FOUND, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_pool(32'hFFFF_FFFF);
      add_beat(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 32'd0, 32'hFFFF_FFFF, 1'b0);
      add_beat(CMD_ALLOC, 32'd1, 32'd0, 1'b1, STATUS_NO_SPACE, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_CHECK, 32'd0, 32'd0, 1'b1, STATUS_OK, 32'd0, 32'd0, 1'b1);
      add_beat(CMD_FREE, 32'd0, 32'd0, 1'b1, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_ALLOC, 32'hFFFF_FFFF, 32'd16, 1'b1, STATUS_OK, 32'd0, 32'd16, 1'b0);
      add_beat(CMD_ALLOC, 32'hFFFF_FFFF, 32'd1, 1'b1, STATUS_DUP_ID, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_ALLOC, 32'd2, 32'd0, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_ALLOC, 32'd3, 32'd100, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_FREE, 32'hFFFF_FFFF, 32'd0, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_ALLOC, 32'd4, 32'd8, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_CHECK, 32'd0, 32'hFFFF_FFFF, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_pool(32'd50);
      add_beat(CMD_ALLOC, 32'd9, 32'd10, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_CHECK, 32'd0, 32'd1, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_FREE, 32'd2, 32'd0, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_FREE, 32'd3, 32'd0, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_FREE, 32'd4, 32'd0, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);
      add_beat(CMD_FREE, 32'd9, 32'd0, 1'b0, STATUS_OK, 32'd0, 32'd0, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         if (table_rows[i].kind == ROW_POOL)
            write_pool_size(table_rows[i].request_size);
         else
            send_beat(table_rows[i].command, table_rows[i].buffer_id,
                      table_rows[i].request_size, table_rows[i].typed,
                      table_rows[i].result);
      end

      // Random phases; each starts from a drained block with a new pool size.
      pool_choice = '{32'd200, 32'hFFFF_FFFF, 32'd4096, 32'd37, 32'd1,
                      32'd0, 32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd0};
      pool_choice[8] = $urandom;
      pool_choice[9] = $urandom_range(2, 500);
      for (int phase = 0; phase < 10; phase++) begin
         write_pool_size(pool_choice[phase]);
         burst = 0;
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 12);
               if ($urandom_range(0, 2) != 0) begin
                  start <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            end
            burst--;
            random_beat(phase == 2);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/bfba_pkg.sv
rtl/bfba_slot_store.sv
rtl/best_fit_buffer_allocator.sv
dv/best_fit_buffer_allocator_test.sv
